@@ design/otb_pkg.sv @@
// Shared types and constants for the Otsu threshold binarizer.
package otb_pkg;

  localparam int BIN_W = 21;
  localparam logic [BIN_W-1:0] BIN_MAX = '1;
  localparam int SCALE_W = 6;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 6'd13;
  localparam logic [7:0] PIX_FG = 8'd255;
  localparam logic [7:0] PIX_BG = 8'd0;
  localparam logic [7:0] THR_MAX = 8'd255;
  localparam logic REQ_HIST = 1'b0;
  localparam logic REQ_CLASS = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIX = 1'b1;
  localparam int SP_W = 14;
  localparam int Q_W = 11;
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    OP_X  = 3'd0,
    OP_Y  = 3'd1,
    OP_P  = 3'd2,
    OP_SQ = 3'd3,
    OP_L  = 3'd4,
    OP_R  = 3'd5
  } mul_op_t;

  typedef struct packed {
    logic    take;
    logic    hupd;
    logic    sinit;
    logic    sread;
    logic    mul_start;
    mul_op_t op;
    logic    capture;
    logic    cmp;
    logic    acc;
    logic    scale;
    logic    div;
    logic    finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_hist;
    logic hist_last;
    logic cut_ok;
    logic cut_last;
    logic mul_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/otb_if.sv @@
// Channel interfaces for pixel input, result output and configuration writes.
interface otb_pix_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel;
  logic       last;
  modport source (output valid, req_type, pixel, last, input ready);
  modport sink (input valid, req_type, pixel, last, output ready);
endinterface

interface otb_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] threshold;
  logic [7:0] pixel_out;
  modport source (output valid, kind, threshold, pixel_out, input ready);
  modport sink (input valid, kind, threshold, pixel_out, output ready);
endinterface

interface otb_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] scale_tenths;
  modport source (output valid, scale_tenths, input ready);
  modport sink (input valid, scale_tenths, output ready);
endinterface

@@ design/otb_mul.sv @@
// Bit-serial shift-add multiplier shared by the cut search.
module otb_mul #(
  parameter int AW = 116,
  parameter int BW = 58
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            done,
  output logic [AW+BW-1:0] prod
);
  localparam int CW = (BW > 1) ? $clog2(BW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [AW:0]   hi;
  logic [BW-1:0] lo;
  logic [AW-1:0] a_r;
  logic [AW:0]   sum;

  assign sum = hi + (lo[0] ? {1'b0, a_r} : '0);
  assign prod = {hi[AW-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi  <= '0;
      lo  <= b;
      a_r <= a;
    end else if (busy) begin
      hi <= {1'b0, sum[AW:1]};
      lo <= {sum[0], lo[BW-1:1]};
    end
  end

endmodule

@@ design/otb_dp.sv @@
// Datapath: histogram memory, running sums, cut search registers and result register.
module otb_dp import otb_pkg::*; #(
  parameter int MAX_PIXELS = 1048576,
  parameter int BINS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st,
  input  logic               in_req_type,
  input  logic [7:0]         in_pixel,
  input  logic               in_last,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_data,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               res_kind,
  output logic [7:0]         res_threshold,
  output logic [7:0]         res_pixel
);
  localparam int NW  = $clog2(MAX_PIXELS + 1);
  localparam int SW  = NW + 8;
  localparam int XW  = NW + SW;
  localparam int PW  = 2 * NW;
  localparam int SQW = 2 * XW;
  localparam int LW  = SQW + PW;
  localparam int BW  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int WPW = BIN_W + 8;

  logic [BIN_W-1:0] bin_mem [BINS];
  logic [BINS-1:0]  bin_vld;
  logic [BIN_W-1:0] rd_data;
  logic             rd_vld;
  logic [BW-1:0]    rd_addr;
  logic             rd_en;
  logic [BW-1:0]    in_idx;
  logic [BW-1:0]    hidx;
  logic [7:0]       hpix;
  logic             hlast;
  logic [BIN_W-1:0] bin_cur;

  logic [NW-1:0]    pixel_total;
  logic [NW-1:0]    n;
  logic [SW-1:0]    s;
  logic [NW-1:0]    n0;
  logic [SW-1:0]    s0;
  logic [NW-1:0]    n1;
  logic [SW-1:0]    s1;
  logic [BW-1:0]    cut_idx;
  logic [BW-1:0]    best;
  logic [XW-1:0]    x;
  logic [XW-1:0]    y;
  logic [XW-1:0]    d;
  logic [PW-1:0]    p;
  logic [SQW-1:0]   sq;
  logic [LW-1:0]    lhs;
  logic [LW-1:0]    rhs;
  logic [SQW-1:0]   best_sq;
  logic [PW-1:0]    best_p;
  logic [WPW-1:0]   wprod;

  logic [SQW-1:0]    mul_a;
  logic [XW-1:0]     mul_b;
  logic              mul_done;
  logic [SQW+XW-1:0] mul_prod;

  logic [SCALE_W-1:0] scale_tenths;
  logic [7:0]         current_threshold;
  logic [SP_W-1:0]    sp;
  logic [Q_W-1:0]     q;
  logic [29:0]        qp;
  logic [SP_W-1:0]    q10;
  logic [3:0]         rem;
  logic               round_up;
  logic [Q_W-1:0]     qr;
  logic [7:0]         thr_new;
  logic               cnt_ok;
  logic               bin_inc;
  logic               out_free;

  assign in_idx = ({1'b0, in_pixel} >= 9'(BINS)) ? BW'(BINS - 1) : in_pixel[BW-1:0];
  assign rd_addr = cmd.take ? in_idx : cut_idx;
  assign rd_en = (cmd.take && in_req_type == REQ_HIST) || cmd.sread;
  assign bin_cur = rd_vld ? rd_data : '0;
  assign cnt_ok = (hpix != 8'd0) && (pixel_total < NW'(MAX_PIXELS));
  assign bin_inc = cnt_ok && (bin_cur < BIN_MAX);

  assign n1 = n - n0;
  assign s1 = s - s0;
  assign d = (x > y) ? (x - y) : (y - x);
  assign wprod = WPW'(bin_cur) * WPW'(cut_idx);

  assign out_free = !res_valid || res_ready;
  assign st.in_hist = (in_req_type == REQ_HIST);
  assign st.hist_last = hlast;
  assign st.cut_ok = (n0 != '0) && (n1 != '0);
  assign st.cut_last = (cut_idx == BW'(BINS - 1));
  assign st.mul_done = mul_done;
  assign st.out_free = out_free;

  always_comb begin
    case (cmd.op)
      OP_X: begin
        mul_a = SQW'(s1);
        mul_b = XW'(n0);
      end
      OP_Y: begin
        mul_a = SQW'(s0);
        mul_b = XW'(n1);
      end
      OP_P: begin
        mul_a = SQW'(n0);
        mul_b = XW'(n1);
      end
      OP_SQ: begin
        mul_a = SQW'(d);
        mul_b = d;
      end
      OP_L: begin
        mul_a = sq;
        mul_b = XW'(best_p);
      end
      OP_R: begin
        mul_a = best_sq;
        mul_b = XW'(p);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otb_mul #(.AW(SQW), .BW(XW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= bin_mem[rd_addr];
    end
    if (cmd.hupd && bin_inc) begin
      bin_mem[hidx] <= bin_cur + BIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= bin_vld[rd_addr];
      end
      if (cmd.finish) begin
        bin_vld <= '0;
      end else if (cmd.hupd && bin_inc) begin
        bin_vld[hidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      hidx  <= in_idx;
      hpix  <= in_pixel;
      hlast <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total <= '0;
      n           <= '0;
      s           <= '0;
    end else if (cmd.finish) begin
      pixel_total <= '0;
      n           <= '0;
      s           <= '0;
    end else if (cmd.hupd) begin
      if (cnt_ok) begin
        pixel_total <= pixel_total + NW'(1);
      end
      if (bin_inc) begin
        n <= n + NW'(1);
        s <= s + SW'(hidx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sinit) begin
      n0      <= '0;
      s0      <= '0;
      cut_idx <= '0;
      best    <= '0;
      best_sq <= '0;
      best_p  <= PW'(1);
    end else begin
      if (cmd.capture) begin
        case (cmd.op)
          OP_X: x <= mul_prod[XW-1:0];
          OP_Y: y <= mul_prod[XW-1:0];
          OP_P: p <= mul_prod[PW-1:0];
          OP_SQ: sq <= mul_prod[SQW-1:0];
          OP_L: lhs <= mul_prod[LW-1:0];
          OP_R: rhs <= mul_prod[LW-1:0];
          default: ;
        endcase
      end
      if (cmd.cmp && (lhs > rhs)) begin
        best_sq <= sq;
        best_p  <= p;
        best    <= cut_idx;
      end
      if (cmd.acc) begin
        n0 <= n0 + NW'(bin_cur);
        s0 <= s0 + SW'(wprod);
        if (!st.cut_last) begin
          cut_idx <= cut_idx + BW'(1);
        end
      end
    end
  end

  assign qp = 30'(sp) * 30'(RECIP_TEN);
  assign q10 = (SP_W'(q) << 3) + (SP_W'(q) << 1);
  assign rem = 4'(sp - q10);
  assign round_up = (rem > 4'd5) || (rem == 4'd5 && q[0]);
  assign qr = q + Q_W'(round_up);
  assign thr_new = (qr > Q_W'(THR_MAX)) ? THR_MAX : qr[7:0];

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      sp <= SP_W'(8'(best)) * SP_W'(scale_tenths);
    end
    if (cmd.div) begin
      q <= Q_W'(qp >> RECIP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_tenths      <= SCALE_RESET;
      current_threshold <= '0;
    end else begin
      if (cfg_we) begin
        scale_tenths <= cfg_data;
      end
      if (cmd.finish) begin
        current_threshold <= thr_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish || (cmd.take && in_req_type == REQ_CLASS)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_kind      <= KIND_REPORT;
      res_threshold <= thr_new;
      res_pixel     <= PIX_BG;
    end else if (cmd.take && in_req_type == REQ_CLASS) begin
      res_kind      <= KIND_PIX;
      res_threshold <= current_threshold;
      res_pixel     <= (in_pixel != 8'd0 && in_pixel > current_threshold) ? PIX_FG : PIX_BG;
    end
  end

endmodule

@@ design/otb_ctrl.sv @@
// Controller: sequences histogram updates, the cut search and threshold scaling.
module otb_ctrl import otb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_HUPD  = 10'b00_0000_0010,
    ST_SREAD = 10'b00_0000_0100,
    ST_SMUL  = 10'b00_0000_1000,
    ST_SWAIT = 10'b00_0001_0000,
    ST_SCMP  = 10'b00_0010_0000,
    ST_SACC  = 10'b00_0100_0000,
    ST_SCALE = 10'b00_1000_0000,
    ST_SDIV  = 10'b01_0000_0000,
    ST_SDONE = 10'b10_0000_0000
  } state_t;

  state_t  state;
  state_t  state_next;
  mul_op_t op;
  mul_op_t op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_X;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      ST_IDLE: begin
        in_ready = st.out_free;
        cmd.take = in_valid && st.out_free;
        if (cmd.take && st.in_hist) begin
          state_next = ST_HUPD;
        end
      end
      ST_HUPD: begin
        cmd.hupd = 1'b1;
        if (st.hist_last) begin
          cmd.sinit  = 1'b1;
          state_next = ST_SREAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SREAD: begin
        cmd.sread = 1'b1;
        if (st.cut_ok) begin
          op_next    = OP_X;
          state_next = ST_SMUL;
        end else begin
          state_next = ST_SACC;
        end
      end
      ST_SMUL: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (st.mul_done) begin
          cmd.capture = 1'b1;
          unique case (op)
            OP_X: op_next = OP_Y;
            OP_Y: op_next = OP_P;
            OP_P: op_next = OP_SQ;
            OP_SQ: op_next = OP_L;
            OP_L: op_next = OP_R;
            default: op_next = OP_X;
          endcase
          state_next = (op == OP_R) ? ST_SCMP : ST_SMUL;
        end
      end
      ST_SCMP: begin
        cmd.cmp    = 1'b1;
        state_next = ST_SACC;
      end
      ST_SACC: begin
        cmd.acc    = 1'b1;
        state_next = st.cut_last ? ST_SCALE : ST_SREAD;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_SDIV;
      end
      ST_SDIV: begin
        cmd.div    = 1'b1;
        state_next = ST_SDONE;
      end
      ST_SDONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/otsu_threshold_binarizer_unit.sv @@
// Top level of the Otsu threshold binarizer: controller, datapath and checks.
// A classify pixel is accepted whenever the result register is free; a histogram
// pixel goes through a bin read, then a write back. The histogram pixel marked last
// starts the cut search, which holds the input off until the threshold report,
// including any stall of the result port before the report: each cut with two nonempty
// classes runs six products through one bit-serial multiplier, one bit per cycle,
// whose operand is 2*NW + 8 bits wide, NW = clog2(MAX_PIXELS + 1); every other
// cut only reads its bin and accumulates. The histogram is cleared at once when
// the threshold report is issued, so no sweep follows reset.
module otsu_threshold_binarizer_unit import otb_pkg::*; #(
  parameter int MAX_PIXELS = 1048576,
  parameter int BINS = 256
) (
  input  logic      clk,
  input  logic      rst,
  otb_pix_if.sink   pix_in,
  otb_res_if.source res_out,
  otb_cfg_if.sink   cfg
);
  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       in_ready;

  assign pix_in.ready = in_ready;
  assign cfg.ready = 1'b1;

  otb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  otb_dp #(.MAX_PIXELS(MAX_PIXELS), .BINS(BINS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .in_req_type   (pix_in.req_type),
    .in_pixel      (pix_in.pixel),
    .in_last       (pix_in.last),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.scale_tenths),
    .res_valid     (res_out.valid),
    .res_ready     (res_out.ready),
    .res_kind      (res_out.kind),
    .res_threshold (res_out.threshold),
    .res_pixel     (res_out.pixel_out)
  );

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    pix_in.ready |-> (!res_out.valid || res_out.ready))
    else $error("input ready while result register is blocked");

  a_class_result: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready && pix_in.req_type == REQ_CLASS)
      |=> (res_out.valid && res_out.kind == KIND_PIX))
    else $error("classify beat produced no pixel result");

  a_search_holds_input: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !pix_in.ready)
    else $error("input accepted during cut search");

  a_report_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!res_out.valid || res_out.ready))
    else $error("threshold report overwrote a pending result");

endmodule

@@ verif/otb_scoreboard.sv @@
`timescale 1ns / 100ps
// Scoreboard class: threshold predictor and queue of expected result beats.
typedef struct packed {
  logic       kind;
  logic [7:0] threshold;
  logic [7:0] pixel_out;
} otsu_result_t;

class otsu_scoreboard;
  localparam int NBINS = 256;
  localparam int FRAME_CAP = 1048576;

  logic [20:0]  bin_cnt [NBINS];
  int unsigned  frame_pixels;
  logic [7:0]   thr_now;
  logic [5:0]   scale;
  otsu_result_t expected_q [$];
  int           errors;

  function new();
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    frame_pixels = 0;
    thr_now = '0;
    scale = otb_pkg::SCALE_RESET;
    errors = 0;
  endfunction

  function void set_scale(logic [5:0] v);
    scale = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function logic [7:0] best_cut();
    longint unsigned n, s, n0, s0, n1, s1, x, y, d, p, best_d, best_p;
    logic [191:0] lhs, rhs;
    logic [7:0] cut;
    n = 0; s = 0; n0 = 0; s0 = 0; best_d = 0; best_p = 1; cut = '0;
    for (int i = 0; i < NBINS; i++) begin
      n += bin_cnt[i];
      s += longint'(bin_cnt[i]) * i;
    end
    for (int i = 0; i < NBINS; i++) begin
      n1 = n - n0;
      s1 = s - s0;
      if (n0 != 0 && n1 != 0) begin
        x = n0 * s1;
        y = n1 * s0;
        d = (x > y) ? x - y : y - x;
        p = n0 * n1;
        lhs = 192'(d) * 192'(d) * 192'(best_p);
        rhs = 192'(best_d) * 192'(best_d) * 192'(p);
        if (lhs > rhs) begin
          best_d = d;
          best_p = p;
          cut = i[7:0];
        end
      end
      n0 += bin_cnt[i];
      s0 += longint'(bin_cnt[i]) * i;
    end
    return cut;
  endfunction

  function logic [7:0] scaled(logic [7:0] cut);
    int unsigned prod, q, r;
    prod = cut * scale;
    q = prod / 10;
    r = prod % 10;
    if (r > 5 || (r == 5 && q[0])) q++;
    return (q > 255) ? otb_pkg::THR_MAX : q[7:0];
  endfunction

  function void note_pixel(logic req, logic [7:0] px, logic lst);
    otsu_result_t e;
    if (req == otb_pkg::REQ_CLASS) begin
      e.kind = otb_pkg::KIND_PIX;
      e.threshold = thr_now;
      e.pixel_out = (px != 0 && px > thr_now) ? otb_pkg::PIX_FG : otb_pkg::PIX_BG;
      expected_q = {expected_q, e};
      return;
    end
    if (px != 0 && frame_pixels < FRAME_CAP) begin
      if (bin_cnt[px] != otb_pkg::BIN_MAX) bin_cnt[px]++;
      frame_pixels++;
    end
    if (!lst) return;
    thr_now = scaled(best_cut());
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    frame_pixels = 0;
    e.kind = otb_pkg::KIND_REPORT;
    e.threshold = thr_now;
    e.pixel_out = otb_pkg::PIX_BG;
    expected_q = {expected_q, e};
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(otsu_result_t got);
    otsu_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected beat kind=%0d thr=%0d pix=%0d",
                       got.kind, got.threshold, got.pixel_out));
      return;
    end
    e = expected_q.pop_front();
    if (got.kind !== e.kind)
      report($sformatf("kind got %0d want %0d", got.kind, e.kind));
    if (got.threshold !== e.threshold)
      report($sformatf("threshold got %0d want %0d", got.threshold, e.threshold));
    if (got.pixel_out !== e.pixel_out)
      report($sformatf("pixel_out got %0d want %0d", got.pixel_out, e.pixel_out));
  endtask
endclass

@@ verif/otsu_threshold_binarizer_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives pixel frames and scale writes, checks every result beat.
module otsu_threshold_binarizer_unit_tb;
  import otb_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_GOAL = 1850;

  logic clk;
  logic rst;
  otb_pix_if pix();
  otb_res_if res();
  otb_cfg_if cfg();

  otsu_scoreboard sb;
  bit gaps_on;
  int hold_cnt;
  int cycles;
  int items_sent;

  otsu_threshold_binarizer_unit u_dut (
    .clk(clk), .rst(rst), .pix_in(pix), .res_out(res), .cfg(cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    pix.valid = 1'b0; pix.req_type = REQ_HIST; pix.pixel = '0; pix.last = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.scale_tenths = '0;
    gaps_on = 1'b1;
    hold_cnt = 0;
    cycles = 0;
    items_sent = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst && pix.valid && pix.ready) sb.note_pixel(pix.req_type, pix.pixel, pix.last);
    if (!rst && res.valid && res.ready)
      sb.check_result('{res.kind, res.threshold, res.pixel_out});
    if (!rst && cfg.valid && cfg.ready) sb.set_scale(cfg.scale_tenths);
  end

  // receiver: random stalls plus a counted hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= !(gaps_on && $urandom_range(99) < 27);
    end
  end

  task automatic send_pix(logic r, logic [7:0] p, logic l);
    while (gaps_on && $urandom_range(99) < 27) begin
      pix.valid = 1'b0;
      @(negedge clk);
    end
    pix.valid = 1'b1; pix.req_type = r; pix.pixel = p; pix.last = l;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    pix.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_scale(logic [5:0] v);
    drain();
    cfg.valid = 1'b1;
    cfg.scale_tenths = v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic hist_frame(int n, int lo, int hi);
    logic [7:0] p;
    for (int i = 0; i < n; i++) begin
      p = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(hi, lo));
      send_pix(REQ_HIST, p, i == n - 1);
    end
  endtask

  task automatic classify_burst(int m);
    for (int i = 0; i < m; i++)
      send_pix(REQ_CLASS, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    int lo, span;
    #1;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed
    send_pix(REQ_CLASS, 8'd0, 1'b0);
    send_pix(REQ_CLASS, 8'd255, 1'b1);
    send_pix(REQ_CLASS, 8'd1, 1'b0);
    send_pix(REQ_HIST, 8'd0, 1'b1);
    send_pix(REQ_HIST, 8'd200, 1'b0);
    send_pix(REQ_HIST, 8'd200, 1'b1);
    send_pix(REQ_HIST, 8'd1, 1'b0);
    send_pix(REQ_HIST, 8'd255, 1'b0);
    send_pix(REQ_HIST, 8'd255, 1'b1);
    send_pix(REQ_CLASS, 8'd255, 1'b0);
    send_pix(REQ_CLASS, 8'd254, 1'b0);
    send_pix(REQ_CLASS, 8'd0, 1'b0);
    write_scale(6'd0);
    send_pix(REQ_HIST, 8'd10, 1'b0);
    send_pix(REQ_HIST, 8'd20, 1'b1);
    write_scale(6'd63);
    send_pix(REQ_HIST, 8'd1, 1'b0);
    send_pix(REQ_HIST, 8'd250, 1'b1);
    send_pix(REQ_CLASS, 8'd13, 1'b0);
    send_pix(REQ_CLASS, 8'd14, 1'b0);
    write_scale(6'd15);
    send_pix(REQ_HIST, 8'd50, 1'b0);
    send_pix(REQ_HIST, 8'd200, 1'b1);
    write_scale(6'd40);
    send_pix(REQ_HIST, 8'd199, 1'b0);
    send_pix(REQ_HIST, 8'd255, 1'b1);
    send_pix(REQ_CLASS, 8'd255, 1'b0);

    // random frames
    for (int ph = 0; items_sent < ITEM_GOAL; ph++) begin
      gaps_on = !(ph >= 8 && ph < 12);
      if ($urandom_range(2) == 0) write_scale(6'($urandom_range(63)));
      if (ph == 5 || ph == 17) begin
        lo = 1; span = 254;
      end else begin
        span = $urandom_range(40);
        lo = $urandom_range(255 - span, 1);
      end
      hist_frame($urandom_range(50, 5), lo, lo + span);
      if (ph == 3) begin
        @(negedge clk);
        hold_cnt = 400;
      end
      if (ph == 6) drain();
      classify_burst($urandom_range(80, 20));
    end

    pix.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
